// ===== rtl/grp_pkg.sv =====
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types and codes of the guillotine rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

  localparam int unsigned REQ_DIM_W = 13;
  localparam int unsigned PLACE_W   = 12;
  localparam int unsigned AREA_W    = 25;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                 cmd;
    logic [REQ_DIM_W-1:0] rect_width;
    logic [REQ_DIM_W-1:0] rect_height;
  } grp_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PLACE_W-1:0]  place_x;
    logic [PLACE_W-1:0]  place_y;
    logic [AREA_W-1:0]   used_area;
  } grp_res_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_LAST,
    IDX_NEXT
  } grp_idx_op_t;

  typedef enum logic [2:0] {
    WR_BIN,
    WR_PA,
    WR_PB,
    WR_SHUP,
    WR_SHDN
  } grp_wr_sel_t;

  typedef struct packed {
    logic                restart;
    logic                capture;
    logic                rd_en;
    logic                take;
    logic                wr_en;
    grp_wr_sel_t         wr_sel;
    grp_idx_op_t         idx_op;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                set_res;
    logic [STATUS_W-1:0] res_code;
    logic                res_place;
    logic                add_area;
    logic                load_out;
  } grp_cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       fits;
    logic [1:0] npieces;
    logic       full;
    logic       up_done;
  } grp_sts_t;

endpackage

// ===== rtl/grp_ram.sv =====
// ----------------------------------------------------------------------------
// grp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/grp_dp.sv =====
// ----------------------------------------------------------------------------
// grp_dp
// Datapath: free list memory, index, counters, split logic and result regs.
// ----------------------------------------------------------------------------
module grp_dp #(
  parameter int unsigned MAX_FREE   = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  grp_pkg::grp_cmd_t                    cmd,
  output grp_pkg::grp_sts_t                    sts,
  input  grp_pkg::grp_req_t                    in_req,
  input  logic                                 cfg_we,
  input  logic [grp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [grp_pkg::REQ_DIM_W-1:0]        cfg_wdata,
  output grp_pkg::grp_res_t                    out_res
);
  import grp_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned CW    = (DW > REQ_DIM_W) ? DW : REQ_DIM_W;
  localparam int unsigned EW    = 2 * CB + 2 * DW;
  localparam int unsigned IDX_W = $clog2(MAX_FREE);
  localparam int unsigned CNT_W = $clog2(MAX_FREE + 1);
  localparam int unsigned PROD_W = 2 * REQ_DIM_W;
  localparam logic [CW-1:0]     DIM_MAX  = CW'(1) << CB;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // entry layout {x, y, w, h}
  function automatic logic [EW-1:0] pack_ent(logic [CB-1:0] x, logic [CB-1:0] y,
                                             logic [DW-1:0] w, logic [DW-1:0] h);
    return {x, y, w, h};
  endfunction

  logic [REQ_DIM_W-1:0] bin_w_r, bin_h_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     idx_r;
  logic [IDX_W-1:0]     found_r;
  logic [AREA_W-1:0]    area_r;
  logic [REQ_DIM_W-1:0] req_w_r, req_h_r;
  logic [PROD_W-1:0]    prod_r;
  logic [CB-1:0]        node_x_r, node_y_r;
  logic [EW-1:0]        pa_r, pb_r;
  logic [1:0]           np_r;
  logic [STATUS_W-1:0]  res_code_r;
  logic [CB-1:0]        res_x_r, res_y_r;
  grp_res_t             out_r;

  logic [EW-1:0]        rd_data;
  logic [CB-1:0]        e_x, e_y;
  logic [DW-1:0]        e_w, e_h;
  logic [DW-1:0]        rw, rh, lw, lh;
  logic [CB-1:0]        xr, yr;
  logic [EW-1:0]        p0, p1;
  logic                 p0_ok, p1_ok;
  logic [CW-1:0]        bw_sat, bh_sat;
  logic                 bin_empty;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [EW-1:0]        wr_data;
  logic [AREA_W+1:0]    area_sum;
  logic [31:0]          place_x32, place_y32;

  assign {e_x, e_y, e_w, e_h} = rd_data;

  // bin size saturated to the coordinate range
  assign bw_sat    = (CW'(bin_w_r) > DIM_MAX) ? DIM_MAX : CW'(bin_w_r);
  assign bh_sat    = (CW'(bin_h_r) > DIM_MAX) ? DIM_MAX : CW'(bin_h_r);
  assign bin_empty = (bin_w_r == '0) || (bin_h_r == '0);

  // split along the shorter leftover axis
  assign rw = DW'(req_w_r);
  assign rh = DW'(req_h_r);
  assign lw = e_w - rw;
  assign lh = e_h - rh;
  assign xr = e_x + CB'(rw);
  assign yr = e_y + CB'(rh);
  always_comb begin
    if (lw <= lh) begin
      p0 = pack_ent(xr, e_y, lw, rh);
      p1 = pack_ent(e_x, yr, e_w, lh);
      p0_ok = (lw != '0) && (rh != '0);
      p1_ok = (e_w != '0) && (lh != '0);
    end else begin
      p0 = pack_ent(e_x, yr, rw, lh);
      p1 = pack_ent(xr, e_y, lw, e_h);
      p0_ok = (rw != '0) && (lh != '0);
      p1_ok = (lw != '0) && (e_h != '0);
    end
  end

  // memory port muxing
  assign wr_en   = cmd.wr_en || (cmd.restart && !bin_empty);
  assign rd_addr = idx_r[IDX_W-1:0];
  always_comb begin
    wr_addr = '0;
    wr_data = pack_ent('0, '0, bw_sat[DW-1:0], bh_sat[DW-1:0]);
    if (!cmd.restart) begin
      unique case (cmd.wr_sel)
        WR_BIN: begin
          wr_addr = '0;
        end
        WR_PA: begin
          wr_addr = found_r;
          wr_data = pa_r;
        end
        WR_PB: begin
          wr_addr = found_r + IDX_W'(1);
          wr_data = pb_r;
        end
        WR_SHUP: begin
          wr_addr = idx_r[IDX_W-1:0] + IDX_W'(1);
          wr_data = rd_data;
        end
        WR_SHDN: begin
          wr_addr = idx_r[IDX_W-1:0] - IDX_W'(1);
          wr_data = rd_data;
        end
        default: begin
          wr_addr = '0;
        end
      endcase
    end
  end

  grp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_FREE)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign area_sum = (AREA_W + 2)'(area_r) + (AREA_W + 2)'(prod_r);

  // status back to the controller
  assign sts.scan_end = (idx_r >= cnt_r);
  assign sts.fits     = (CW'(req_w_r) <= CW'(e_w)) && (CW'(req_h_r) <= CW'(e_h));
  assign sts.npieces  = np_r;
  assign sts.full     = (cnt_r >= CNT_W'(MAX_FREE));
  assign sts.up_done  = (idx_r == CNT_W'(found_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_w_r <= REQ_DIM_W'(1024);
      bin_h_r <= REQ_DIM_W'(1024);
      cnt_r   <= '0;
      area_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BIN_WIDTH:  bin_w_r <= cfg_wdata;
          CFG_BIN_HEIGHT: bin_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.restart) begin
        cnt_r  <= bin_empty ? '0 : CNT_W'(1);
        area_r <= '0;
      end else begin
        if (cmd.cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
        if (cmd.cnt_dec) cnt_r <= cnt_r - CNT_W'(1);
        if (cmd.add_area) begin
          area_r <= (area_sum > (AREA_W + 2)'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= req_w_r * req_h_r;
    if (cmd.capture) begin
      req_w_r <= in_req.rect_width;
      req_h_r <= in_req.rect_height;
    end
    unique case (cmd.idx_op)
      IDX_HOLD: ;
      IDX_ZERO: idx_r <= '0;
      IDX_INC:  idx_r <= idx_r + CNT_W'(1);
      IDX_DEC:  idx_r <= idx_r - CNT_W'(1);
      IDX_LAST: idx_r <= cnt_r - CNT_W'(1);
      IDX_NEXT: idx_r <= CNT_W'(found_r) + CNT_W'(1);
      default: ;
    endcase
    if (cmd.take) begin
      found_r  <= idx_r[IDX_W-1:0];
      node_x_r <= e_x;
      node_y_r <= e_y;
      pa_r     <= p0_ok ? p0 : p1;
      pb_r     <= p1;
      np_r     <= 2'(p0_ok) + 2'(p1_ok);
    end
    if (cmd.set_res) begin
      res_code_r <= cmd.res_code;
      res_x_r    <= cmd.res_place ? node_x_r : '0;
      res_y_r    <= cmd.res_place ? node_y_r : '0;
    end
    if (cmd.load_out) begin
      out_r.status    <= res_code_r;
      out_r.place_x   <= place_x32[PLACE_W-1:0];
      out_r.place_y   <= place_y32[PLACE_W-1:0];
      out_r.used_area <= area_r;
    end
  end

  assign place_x32 = 32'(res_x_r);
  assign place_y32 = 32'(res_y_r);
  assign out_res   = out_r;

endmodule

// ===== rtl/grp_ctrl.sv =====
// ----------------------------------------------------------------------------
// grp_ctrl
// Controller: sequences scan, split, list shifting and result transfer.
// ----------------------------------------------------------------------------
module grp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output grp_pkg::grp_cmd_t cmd,
  input  grp_pkg::grp_sts_t sts
);
  import grp_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SPLIT,
    S_UP_RD,
    S_UP_WR,
    S_WR_PB,
    S_DN_RD,
    S_DN_WR,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy;

  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.wr_sel    = WR_BIN;
    cmd.idx_op    = IDX_HOLD;
    cmd.res_code  = ST_OK;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_INIT: begin
        cmd.restart = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_RESTART) begin
            cmd.restart  = 1'b1;
            cmd.set_res  = 1'b1;
            state_nxt    = S_FINISH;
          end else begin
            cmd.capture = 1'b1;
            cmd.idx_op  = IDX_ZERO;
            state_nxt   = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOFIT;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.fits) begin
          cmd.take  = 1'b1;
          state_nxt = S_SPLIT;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        priority if (sts.npieces == 2'd2 && sts.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_nxt    = S_FINISH;
        end else if (sts.npieces == 2'd1) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_PA;
          cmd.set_res   = 1'b1;
          cmd.res_place = 1'b1;
          cmd.add_area  = 1'b1;
          state_nxt     = S_FINISH;
        end else if (sts.npieces == 2'd2) begin
          cmd.idx_op = IDX_LAST;
          state_nxt  = S_UP_RD;
        end else begin
          cmd.idx_op = IDX_NEXT;
          state_nxt  = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (sts.up_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_PA;
          state_nxt  = S_WR_PB;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHUP;
        cmd.idx_op = IDX_DEC;
        state_nxt  = S_UP_RD;
      end
      S_WR_PB: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_PB;
        cmd.cnt_inc   = 1'b1;
        cmd.set_res   = 1'b1;
        cmd.res_place = 1'b1;
        cmd.add_area  = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_DN_RD: begin
        if (sts.scan_end) begin
          cmd.cnt_dec   = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_place = 1'b1;
          cmd.add_area  = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHDN;
        cmd.idx_op = IDX_INC;
        state_nxt  = S_DN_RD;
      end
      S_FINISH: begin
        if (!out_busy) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/guillotine_rect_packer.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer
// Online first-fit rectangle allocator over a guillotine-split free list.
// ----------------------------------------------------------------------------
// An insert scans the ordered free list from the front, reading and comparing
// one entry at a time, takes the first entry that holds the request, reports
// its corner and replaces the entry by its non-empty split pieces. The free
// list lives in one single-port-write RAM, so the time per item is set by that
// memory port: an insert scans up to the fill count of entries, then splits,
// and moves the entries behind the chosen one when the list grows or shrinks.
// Only one item is in work at a time; the result sits in an output register,
// so a new item is taken while that result waits. After reset the block first
// loads the whole bin as entry zero.
// ----------------------------------------------------------------------------
module guillotine_rect_packer #(
  parameter int unsigned MAX_FREE   = 256,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  grp_pkg::grp_req_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output grp_pkg::grp_res_t             out_data,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [grp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grp_pkg::REQ_DIM_W-1:0] cfg_wdata
);
  import grp_pkg::*;

  grp_cmd_t cmd;
  grp_sts_t sts;

  // sequencing: scan, split, shift and result transfer
  grp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // free list memory, split arithmetic and area total
  grp_dp #(
    .MAX_FREE   (MAX_FREE),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the guillotine rectangle packer.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. It covers the corner cases:
// an exact fill, an oversized request, a zero-sized request, restart and
// full-bin edge sizes. Random phases follow, each with its own bin setting:
// a tiny bin, saturated bins, a zero bin, thin bins, and a run that fills the
// free list until it is full. Every accepted request goes through a local
// first-fit model. Each result transfer is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import grp_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam int DIM_CAP    = 4096;
  localparam int AREA_CAP   = (1 << AREA_W) - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 1100;   // worst insert: full scan plus full shift
  localparam int HOLD_LEN   = 400;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  grp_req_t in_data;
  logic     out_valid;
  logic     out_stall;
  grp_res_t out_data;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REQ_DIM_W-1:0] cfg_wdata;

  guillotine_rect_packer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // local copy of the packer state
  int     bin_w, bin_h;
  int     free_x[LIST_DEPTH], free_y[LIST_DEPTH], free_w[LIST_DEPTH], free_h[LIST_DEPTH];
  int     free_cnt;
  longint placed_area;

  // predicted results, oldest first
  grp_res_t pending_res[$];

  // what the driver currently offers, read by the request monitor
  bit       offer_typed;
  grp_res_t offer_res;

  int  err_cnt, req_cnt, res_cnt, idle_cycles;
  int  n_placed, n_nofit, n_full, n_restart, peak_fill;
  bit  hold_req;

  // directed table; typed rows carry a hand-written expected result
  typedef struct {
    int cmd, w, h, typed, st, px, py, area;
  } dir_row_t;

  localparam int N_DIR = 16;
  dir_row_t dir_tab[N_DIR] = '{
    '{CMD_INSERT,  1024, 1024, 1, ST_OK,    0, 0, 1048576}, // exact fill of the bin
    '{CMD_INSERT,     1,    1, 1, ST_NOFIT, 0, 0, 1048576}, // nothing left
    '{CMD_RESTART,    0,    0, 1, ST_OK,    0, 0, 0},
    '{CMD_INSERT,  8191, 8191, 1, ST_NOFIT, 0, 0, 0},       // all ones never fits
    '{CMD_INSERT,     0,    0, 1, ST_OK,    0, 0, 0},       // zero size, no area
    '{CMD_INSERT,  1025,    1, 1, ST_NOFIT, 0, 0, 0},
    '{CMD_INSERT,  4096, 4096, 1, ST_NOFIT, 0, 0, 0},
    '{CMD_INSERT,   100,   50, 0, 0, 0, 0, 0},
    '{CMD_INSERT,    50,  100, 0, 0, 0, 0, 0},
    '{CMD_INSERT,     0,    7, 0, 0, 0, 0, 0},
    '{CMD_INSERT,  1024,    1, 0, 0, 0, 0, 0},
    '{CMD_INSERT,     1, 1024, 0, 0, 0, 0, 0},
    '{CMD_INSERT,  5000,    3, 0, 0, 0, 0, 0},
    '{CMD_INSERT,   300,  300, 0, 0, 0, 0, 0},
    '{CMD_RESTART, 8191, 8191, 1, ST_OK,    0, 0, 0},       // size fields ignored
    '{CMD_INSERT,   512,  700, 0, 0, 0, 0, 0}
  };

  function automatic void reload_bin();
    int w, h;
    w = (bin_w > DIM_CAP) ? DIM_CAP : bin_w;
    h = (bin_h > DIM_CAP) ? DIM_CAP : bin_h;
    placed_area = 0;
    free_cnt = 0;
    if (w != 0 && h != 0) begin
      free_x[0] = 0;
      free_y[0] = 0;
      free_w[0] = w;
      free_h[0] = h;
      free_cnt = 1;
    end
  endfunction

  // first-fit placement with a shorter-axis guillotine split
  function automatic grp_res_t pack_step(grp_req_t r);
    grp_res_t o;
    int rw, rh, k, hit, lw, lh, np, nx, ny, nw, nh;
    int px[2], py[2], pw[2], ph[2], kx[2], ky[2], kw[2], kh[2];
    o = '0;
    o.status = ST_NOFIT;
    if (r.cmd == CMD_RESTART) begin
      reload_bin();
      o.status = ST_OK;
      return o;
    end
    rw = int'(r.rect_width);
    rh = int'(r.rect_height);
    hit = -1;
    for (k = 0; k < free_cnt; k++) begin
      if (rw <= free_w[k] && rh <= free_h[k]) begin
        hit = k;
        break;
      end
    end
    if (hit >= 0) begin
      nx = free_x[hit];
      ny = free_y[hit];
      nw = free_w[hit];
      nh = free_h[hit];
      lw = nw - rw;
      lh = nh - rh;
      if (lw <= lh) begin
        px[0] = nx + rw; py[0] = ny;      pw[0] = lw; ph[0] = rh;
        px[1] = nx;      py[1] = ny + rh; pw[1] = nw; ph[1] = lh;
      end else begin
        px[0] = nx;      py[0] = ny + rh; pw[0] = rw; ph[0] = lh;
        px[1] = nx + rw; py[1] = ny;      pw[1] = lw; ph[1] = nh;
      end
      np = 0;
      for (k = 0; k < 2; k++) begin
        if (pw[k] != 0 && ph[k] != 0) begin
          kx[np] = px[k]; ky[np] = py[k]; kw[np] = pw[k]; kh[np] = ph[k];
          np++;
        end
      end
      if (np == 2 && free_cnt >= LIST_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        if (np == 0) begin
          for (k = hit; k < free_cnt - 1; k++) begin
            free_x[k] = free_x[k+1]; free_y[k] = free_y[k+1];
            free_w[k] = free_w[k+1]; free_h[k] = free_h[k+1];
          end
          free_cnt--;
        end else begin
          if (np == 2) begin
            for (k = free_cnt; k > hit + 1; k--) begin
              free_x[k] = free_x[k-1]; free_y[k] = free_y[k-1];
              free_w[k] = free_w[k-1]; free_h[k] = free_h[k-1];
            end
            free_x[hit+1] = kx[1]; free_y[hit+1] = ky[1];
            free_w[hit+1] = kw[1]; free_h[hit+1] = kh[1];
            free_cnt++;
          end
          free_x[hit] = kx[0]; free_y[hit] = ky[0];
          free_w[hit] = kw[0]; free_h[hit] = kh[0];
        end
        placed_area += longint'(rw) * longint'(rh);
        if (placed_area > AREA_CAP) placed_area = AREA_CAP;
        o.status  = ST_OK;
        o.place_x = nx[PLACE_W-1:0];
        o.place_y = ny[PLACE_W-1:0];
      end
    end
    o.used_area = placed_area[AREA_W-1:0];
    if (free_cnt > peak_fill) peak_fill = free_cnt;
    return o;
  endfunction

  // request monitor: predict on every accepted transfer
  always @(posedge clk) begin
    grp_res_t p;
    if (rst_n && in_valid && !in_stall) begin
      p = pack_step(in_data);
      pending_res.push_back(offer_typed ? offer_res : p);
      req_cnt++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    grp_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      res_cnt++;
      case (out_data.status)
        ST_OK:    n_placed++;
        ST_NOFIT: n_nofit++;
        ST_FULL:  n_full++;
        default:  ;
      endcase
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        err_cnt++;
      end else begin
        e = pending_res.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          err_cnt++;
        end
        if (out_data.place_x !== e.place_x) begin
          $error("place_x: expected %0d, got %0d", e.place_x, out_data.place_x);
          err_cnt++;
        end
        if (out_data.place_y !== e.place_y) begin
          $error("place_y: expected %0d, got %0d", e.place_y, out_data.place_y);
          err_cnt++;
        end
        if (out_data.used_area !== e.used_area) begin
          $error("used_area: expected %0d, got %0d", e.used_area, out_data.used_area);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("guillotine_rect_packer test failed");
      $finish;
    end
  end

  // receiver: randomly chosen stall patterns, plus one long hold-off
  initial begin
    int mode, tick;
    mode = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        tick++;
        if (tick % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 1);
          2: out_stall <= (tick % 3 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // sender burst state
  int burst_left;

  task automatic send_req(input grp_req_t r, input bit typed, input grp_res_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_data     <= r;
    offer_typed <= typed;
    offer_res   <= res;
    do @(posedge clk); while (in_stall);
  endtask

  // let the block finish everything before touching the bin registers
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[REQ_DIM_W-1:0];
    if (idx == CFG_BIN_WIDTH) bin_w = val & 13'h1fff;
    else bin_h = val & 13'h1fff;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_dim(int lim, int cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 8) return $urandom_range(0, 8191);     // wide random, mostly oversized
    if (r < 12) return lim;
    if (lim < 1) return $urandom_range(1, 8);
    return $urandom_range(1, (cap < lim) ? cap : lim);
  endfunction

  // one random phase: new bin, restart, then mostly inserts
  task automatic run_phase(input int bw, input int bh, input int n, input int cap,
                           input bit with_hold);
    grp_req_t r;
    int k, lw, lh;
    drain();
    write_reg(CFG_BIN_WIDTH, bw);
    write_reg(CFG_BIN_HEIGHT, bh);
    r = '0;
    r.cmd = CMD_RESTART;
    send_req(r, 1'b0, '0);
    lw = (bw > DIM_CAP) ? DIM_CAP : bw;
    lh = (bh > DIM_CAP) ? DIM_CAP : bh;
    for (k = 0; k < n; k++) begin
      if (with_hold && k == n / 3) hold_req = 1'b1;
      r.cmd = ($urandom_range(0, 99) < 2) ? CMD_RESTART : CMD_INSERT;
      r.rect_width  = REQ_DIM_W'(pick_dim(lw, cap));
      r.rect_height = REQ_DIM_W'(pick_dim(lh, cap));
      send_req(r, 1'b0, '0);
    end
  endtask

  initial begin
    grp_req_t r;
    grp_res_t e;
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    offer_typed = 1'b0;
    offer_res = '0;
    hold_req = 1'b0;
    burst_left = 0;
    err_cnt = 0; req_cnt = 0; res_cnt = 0; idle_cycles = 0;
    n_placed = 0; n_nofit = 0; n_full = 0; peak_fill = 0;
    bin_w = 1024;
    bin_h = 1024;
    reload_bin();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at the reset bin size
    for (k = 0; k < N_DIR; k++) begin
      r.cmd         = dir_tab[k].cmd[0];
      r.rect_width  = dir_tab[k].w[REQ_DIM_W-1:0];
      r.rect_height = dir_tab[k].h[REQ_DIM_W-1:0];
      e.status    = dir_tab[k].st[STATUS_W-1:0];
      e.place_x   = dir_tab[k].px[PLACE_W-1:0];
      e.place_y   = dir_tab[k].py[PLACE_W-1:0];
      e.used_area = dir_tab[k].area[AREA_W-1:0];
      send_req(r, dir_tab[k].typed != 0, e);
    end

    // random phases; the thin and tiny bins keep the scans short
    run_phase(1024, 1024, 150, 256, 1'b1);
    run_phase(1, 1, 40, 1, 1'b0);
    run_phase(4096, 4096, 420, 4, 1'b0);   // small requests grow the list until full
    run_phase(8191, 8191, 100, 2048, 1'b0);
    run_phase(0, 5, 30, 8, 1'b0);
    run_phase(37, 200, 150, 40, 1'b0);
    run_phase(4096, 1, 60, 512, 1'b0);
    run_phase(300, 8191, 150, 300, 1'b0);
    run_phase(1024, 1024, 150, 128, 1'b0);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d requests over 9 bin settings, %0d results checked", req_cnt,
             res_cnt);
    $display("placed %0d, no fit %0d, list full %0d, peak free list fill %0d",
             n_placed, n_nofit, n_full, peak_fill);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("guillotine_rect_packer test passed");
    end else begin
      $display("guillotine_rect_packer test failed");
    end
    $finish;
  end

endmodule
